// ===== hw/rtl/ffca_pkg.sv =====
// package: shared types and constants of the first-fit cell allocator
package ffca_pkg;
    localparam int ARENA_CELLS_DEF = 1024;
    localparam int MAX_ALLOCS_DEF  = 256;
    localparam int CFG_W    = 11;
    localparam int CMD_W    = 2;
    localparam int SIZE_W   = 11;
    localparam int ID_W     = 8;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 10;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_EXT   = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NO_SPACE = 3'd1,
        ST_NO_ID    = 3'd2,
        ST_FULL     = 3'd3,
        ST_BAD_SIZE = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        REG_ARENA = 1'b0,
        REG_ALIGN = 1'b1
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE, S_REC, S_RECW, S_SCAN, S_SCANW, S_MARK,
        S_FREE, S_FREEW, S_EXTCHK, S_EXTCHKW, S_CLEAR, S_OUT
    } t_state;
endpackage

// ===== hw/rtl/first_fit_cell_allocator_unit.sv =====
// top level: first-fit cell allocator with cell and record memories
// allocate examines cells, then marks the run; bad size or a full table skips the scan;
// free releases the cells of the id; extend checks cells past the old end, then marks them;
// unknown id or extend without growth touches no cell; reset-all clears every cell
// throughput: one request at a time, next one accepted the cycle after its result is registered
// reset: synchronous active low, then a sweep over all ARENA_CELLS cells clears the cell memory
module first_fit_cell_allocator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_index,
    input  logic [ffca_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ffca_pkg::CMD_W-1:0]    i_cmd,
    input  logic [ffca_pkg::SIZE_W-1:0]   i_cell_cnt,
    input  logic [ffca_pkg::ID_W-1:0]     i_alloc_id,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ffca_pkg::STATUS_W-1:0] o_status,
    output logic [ffca_pkg::ID_W-1:0]     o_result_id,
    output logic [ffca_pkg::POS_W-1:0]    o_result_start,
    output logic [ffca_pkg::POS_W-1:0]    o_result_end
);
    import ffca_pkg::*;

    localparam int ARENA_CELLS = ARENA_CELLS_DEF;
    localparam int MAX_ALLOCS  = MAX_ALLOCS_DEF;
    localparam int AW = $clog2(ARENA_CELLS);
    localparam int RW = $clog2(MAX_ALLOCS);
    localparam int CW = AW + 2;           // wide enough for sums of two positions
    localparam int NW = RW + 1;
    localparam logic [CW-1:0] LAST_CELL = CW'(ARENA_CELLS - 1);

    // cell memory: used flag and owner id per cell
    logic [ID_W:0]     cell_mem [ARENA_CELLS];
    logic [ID_W:0]     r_cell_q;
    logic              cell_we;
    logic [AW-1:0]     cell_addr;
    logic [ID_W:0]     cell_wd;
    // record memory: start and end per id, valid flags in flops
    logic [2*CW-1:0]   rec_mem [MAX_ALLOCS];
    logic [2*CW-1:0]   r_rec_q;
    logic              rec_we;
    logic [RW-1:0]     rec_addr;
    logic [2*CW-1:0]   rec_wd;
    logic [MAX_ALLOCS-1:0] r_rec_valid;

    always_ff @(posedge i_clk) begin
        if (cell_we) cell_mem[cell_addr] <= cell_wd;
        r_cell_q <= cell_mem[cell_addr];
        if (rec_we) rec_mem[rec_addr] <= rec_wd;
        r_rec_q <= rec_mem[rec_addr];
    end

    // config registers
    logic [CFG_W-1:0] r_arena, r_align;
    logic [CW-1:0] eff_n, step;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena <= CFG_W'(ARENA_CELLS);
            r_align <= CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_index))
                REG_ARENA: r_arena <= i_cfg_data;
                REG_ALIGN: r_align <= i_cfg_data;
                default: ;
            endcase
        end
    end
    // saturate arena to the physical cell count
    assign eff_n = (32'(r_arena) > ARENA_CELLS) ? CW'(ARENA_CELLS) : CW'(r_arena);
    assign step  = (r_align == '0) ? CW'(1) : CW'(r_align);

    t_state r_state, n_state;
    logic              r_init;    // power-up sweep of the cell memory, no result
    logic [CMD_W-1:0]  r_cmd;
    logic [SIZE_W-1:0] r_size;
    logic [ID_W-1:0]   r_id;
    logic [NW-1:0]     r_next_id;
    logic [CW-1:0]     r_s;       // candidate start / range start
    logic [CW-1:0]     r_i;       // walking cell pointer
    logic [CW-1:0]     r_e;       // range end
    // working result, built while the request runs
    logic [STATUS_W-1:0] r_st;
    logic [ID_W-1:0]   r_oid;
    logic [POS_W-1:0]  r_os, r_oe;
    // result register toward the receiver
    logic              r_ovalid;
    logic [STATUS_W-1:0] r_res_st;
    logic [ID_W-1:0]   r_res_id;
    logic [POS_W-1:0]  r_res_start, r_res_end;

    logic [CW-1:0] s_plus;
    logic [CW-1:0] rs, re;
    logic [CW-1:0] rec_len, rec_new_end, ext_end;
    logic id_ok;
    logic table_full;
    logic scan_fail;
    logic ext_grow;
    logic free_last;
    logic out_go;

    assign s_plus      = r_s + CW'(r_size);
    assign rs          = r_rec_q[2*CW-1:CW];
    assign re          = r_rec_q[CW-1:0];
    assign rec_len     = re - rs + CW'(1);
    assign rec_new_end = rs + CW'(r_size) - CW'(1);
    assign ext_end     = r_s + CW'(r_size) - CW'(1);
    assign id_ok       = (32'(r_id) < MAX_ALLOCS) && r_rec_valid[r_id[RW-1:0]];
    assign table_full  = (32'(r_next_id) >= MAX_ALLOCS);
    // candidate start valid only if run fits and start in arena
    assign scan_fail   = (r_s >= eff_n) || (s_plus > eff_n);
    // extend that needs new cells and stays inside the arena
    assign ext_grow    = (CW'(r_size) > rec_len) && (rec_new_end < eff_n);
    assign free_last   = (r_i == r_e) || (r_i == LAST_CELL);
    // finished result moves to the output register once it is free
    assign out_go      = (r_state == S_OUT) && (!r_ovalid || i_ready);

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_status = r_res_st;
    assign o_result_id = r_res_id;
    assign o_result_start = r_res_start;
    assign o_result_end = r_res_end;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                unique case (t_cmd'(i_cmd)) inside
                    CMD_ALLOC: begin
                        if (i_cell_cnt == '0 || table_full) n_state = S_OUT;
                        else n_state = S_SCAN;
                    end
                    CMD_FREE, CMD_EXT: n_state = S_REC;
                    CMD_CLEAR: n_state = S_CLEAR;
                    default: ;
                endcase
            end
            S_REC: n_state = S_RECW;
            S_RECW: begin
                if (!id_ok) n_state = S_OUT;
                else if (r_cmd == CMD_FREE) n_state = S_FREE;
                else if (ext_grow) n_state = S_EXTCHK;
                else n_state = S_OUT;
            end
            S_SCAN: begin
                if (scan_fail) n_state = S_OUT;
                else if (r_i == s_plus) n_state = S_MARK;
                else n_state = S_SCANW;
            end
            S_SCANW: n_state = S_SCAN;
            S_MARK: if (r_i == r_e) n_state = S_OUT;
            S_FREE: n_state = S_FREEW;
            S_FREEW: n_state = free_last ? S_OUT : S_FREE;
            S_EXTCHK: n_state = S_EXTCHKW;
            S_EXTCHKW: begin
                if (r_cell_q[ID_W]) n_state = S_OUT;
                else if (r_i == ext_end) n_state = S_MARK;
                else n_state = S_EXTCHK;
            end
            S_CLEAR: if (r_i == LAST_CELL) n_state = r_init ? S_IDLE : S_OUT;
            S_OUT: if (out_go) n_state = S_IDLE;
            default: ;
        endcase
    end

    // memory port control
    always_comb begin
        cell_we = 1'b0; cell_addr = r_i[AW-1:0]; cell_wd = {1'b1, r_id};
        rec_we = 1'b0; rec_addr = r_id[RW-1:0]; rec_wd = {r_s, r_e};
        unique case (r_state)
            S_MARK: begin cell_we = 1'b1; end
            S_CLEAR: begin cell_we = 1'b1; cell_wd = '0; end
            S_FREEW: begin
                // only cells still owned by this id are released
                cell_we = r_cell_q[ID_W] && (r_cell_q[ID_W-1:0] == r_id);
                cell_wd = '0;
            end
            S_OUT: begin
                rec_we = out_go && (r_st == ST_OK) &&
                         ((r_cmd == CMD_ALLOC) || (r_cmd == CMD_EXT));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_init <= 1'b1;
            r_i <= '0;
            r_ovalid <= 1'b0;
            r_next_id <= '0;
            r_rec_valid <= '0;
        end else begin
            r_state <= n_state;
            if (out_go) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_cmd <= i_cmd; r_size <= i_cell_cnt; r_id <= i_alloc_id;
                    r_s <= '0; r_i <= '0;
                    r_oid <= '0; r_os <= '0; r_oe <= '0;
                    if (t_cmd'(i_cmd) == CMD_ALLOC && i_cell_cnt == '0) r_st <= ST_BAD_SIZE;
                    else if (t_cmd'(i_cmd) == CMD_ALLOC && table_full) r_st <= ST_FULL;
                    else r_st <= ST_OK;
                end
                S_RECW: begin
                    r_oid <= r_id;
                    if (!id_ok) begin
                        r_st <= ST_NO_ID;
                    end else begin
                        r_s <= rs; r_e <= re;
                        r_os <= rs[POS_W-1:0]; r_oe <= re[POS_W-1:0];
                        if (r_cmd == CMD_FREE) begin
                            r_i <= rs;
                        end else begin
                            r_i <= re + CW'(1);
                            // equal size keeps the record and the ok status
                            if (CW'(r_size) < rec_len) r_st <= ST_BAD_SIZE;
                            else if (CW'(r_size) > rec_len && !ext_grow) r_st <= ST_NO_SPACE;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_fail) begin
                        r_st <= ST_NO_SPACE;
                    end else if (r_i == s_plus) begin
                        r_i <= r_s; r_e <= s_plus - CW'(1);
                        r_id <= r_next_id[ID_W-1:0];
                    end
                end
                S_SCANW: begin
                    if (r_cell_q[ID_W]) begin
                        r_s <= r_s + step; r_i <= r_s + step;
                    end else r_i <= r_i + CW'(1);
                end
                S_MARK: begin
                    if (r_i == r_e) begin
                        r_oid <= r_id; r_os <= r_s[POS_W-1:0]; r_oe <= r_e[POS_W-1:0];
                    end else r_i <= r_i + CW'(1);
                end
                S_FREEW: begin
                    if (free_last) r_rec_valid[r_id[RW-1:0]] <= 1'b0;
                    else r_i <= r_i + CW'(1);
                end
                S_EXTCHKW: begin
                    if (r_cell_q[ID_W]) begin
                        r_st <= ST_NO_SPACE;
                    end else if (r_i == ext_end) begin
                        // all clear: mark from old end + 1
                        r_i <= r_e + CW'(1);
                        r_e <= r_i;
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_CLEAR: begin
                    if (r_i == LAST_CELL) r_init <= 1'b0;
                    else r_i <= r_i + CW'(1);
                end
                S_OUT: if (out_go) begin
                    r_res_st <= r_st;
                    r_res_id <= r_oid;
                    r_res_start <= r_os;
                    r_res_end <= r_oe;
                    if (r_cmd == CMD_ALLOC && r_st == ST_OK) begin
                        r_rec_valid[r_id[RW-1:0]] <= 1'b1;
                        r_next_id <= r_next_id + NW'(1);
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
